[hw/rtl/ams_pkg.sv]
// ----------------------------------------------------------------------------
// ams_pkg
// Shared types and constants of the accelerometer magnitude smoother.
// ----------------------------------------------------------------------------
package ams_pkg;

    localparam int unsigned AXIS_W     = 16;
    localparam int unsigned ABS_W      = 17;
    localparam int unsigned ROOT_W     = 16;
    localparam int unsigned SCALE_W    = 17;
    localparam int unsigned WEIGHT_W   = 10;
    localparam int unsigned UG_W       = 25;
    localparam int unsigned MUL_A_W    = 25;
    localparam int unsigned MUL_B_W    = 17;
    localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;
    localparam int unsigned SUMSQ_W    = 32;
    localparam int unsigned SUB_W      = 19;
    localparam int unsigned DIVISOR_W  = WEIGHT_W + 1;
    localparam int unsigned DVD_W      = UG_W + DIVISOR_W;
    localparam int unsigned CNT_W      = 5;
    localparam int unsigned FRAME_HELD = 5;
    localparam int unsigned POS_W      = 3;

    localparam logic [UG_W-1:0]     MAG_MAX         = 25'd29100000;
    localparam logic [UG_W-1:0]     AVG_RESET       = 25'd900000;
    localparam logic [SCALE_W-1:0]  LSB_SCALE_RESET = 17'd15024;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET    = 10'd10;
    localparam logic [POS_W-1:0]    LAST_HELD_POS   = 3'd4;
    localparam logic [POS_W-1:0]    FINAL_POS       = 3'd5;

    // Iteration ends of the sequencer
    localparam logic [CNT_W-1:0] SQUARE_LAST = 5'd3;
    localparam logic [CNT_W-1:0] ROOT_LAST   = 5'd15;
    localparam logic [CNT_W-1:0] DIV_LAST    = 5'd24;

    // Register decode on paddr[2]
    localparam logic REG_LSB_SCALE     = 1'b0;
    localparam logic REG_FILTER_WEIGHT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_SCALE,
        ST_CLAMP,
        ST_WEIGHT,
        ST_SUM,
        ST_DIVIDE,
        ST_DONE
    } ams_state_t;

    typedef struct packed {
        logic [AXIS_W-1:0] z;
        logic [AXIS_W-1:0] y;
        logic [AXIS_W-1:0] x;
    } ams_axes_t;

    typedef struct packed {
        logic [UG_W-1:0] smoothed_ug;
        logic [UG_W-1:0] magnitude_ug;
    } ams_result_t;

    typedef struct packed {
        logic start;
        logic out_ready;
    } ams_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ams_status_t;

endpackage

[hw/rtl/ams_core.sv]
// ----------------------------------------------------------------------------
// ams_core
// Iterative datapath: sum of squares, integer root, scaling, moving average.
// One multiplier and one subtractor are shared under a small sequencer.
// ----------------------------------------------------------------------------
module ams_core #(
    parameter int unsigned SCALE_FRAC_BITS = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  ams_pkg::ams_ctrl_t                 ctrl,
    input  ams_pkg::ams_axes_t                 axes,
    input  logic [ams_pkg::SCALE_W-1:0]        lsb_scale,
    input  logic [ams_pkg::WEIGHT_W-1:0]       filter_weight,
    output ams_pkg::ams_status_t               status,
    output ams_pkg::ams_result_t               result
);
    import ams_pkg::*;

    ams_state_t            state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [ABS_W-1:0]      ax_reg, ay_reg, az_reg;
    logic [ABS_W-1:0]      ax_next, ay_next, az_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [SUMSQ_W-1:0]    acc_reg, acc_next;
    logic [SUB_W-1:0]      rem_reg, rem_next;
    logic [ROOT_W-1:0]     root_reg, root_next;
    logic [UG_W-1:0]       mag_reg, mag_next;
    logic [UG_W-1:0]       dvd_reg, dvd_next;
    logic [UG_W-1:0]       avg_reg, avg_next;

    logic [MUL_A_W-1:0]    mul_a;
    logic [MUL_B_W-1:0]    mul_b;
    logic [PROD_W-1:0]     product;
    logic [SUB_W-1:0]      sub_a, sub_b;
    logic [SUB_W:0]        diff;
    logic                  ge;
    logic [PROD_W-1:0]     scaled;
    logic [DVD_W-1:0]      dvd_sum;
    logic [DIVISOR_W-1:0]  divisor;

    function automatic logic [ABS_W-1:0] axis_abs(input logic [AXIS_W-1:0] raw);
        logic [ABS_W-1:0] wide;
        wide = {1'b0, raw};
        if (raw[AXIS_W-1]) begin
            return 17'h10000 - wide;
        end
        return wide;
    endfunction

    // Shared units
    assign product = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign diff    = {1'b0, sub_a} - {1'b0, sub_b};
    assign ge      = ~diff[SUB_W];

    assign divisor = {1'b0, filter_weight} + DIVISOR_W'(1);
    assign scaled  = prod_reg >> SCALE_FRAC_BITS;
    assign dvd_sum = {1'b0, prod_reg[DVD_W-2:0]} + DVD_W'(mag_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            avg_reg   <= AVG_RESET;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            avg_reg   <= avg_next;
        end
    end

    always_ff @(posedge aclk) begin
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        az_reg   <= az_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        mag_reg  <= mag_next;
        dvd_reg  <= dvd_next;
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        az_next    = az_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        mag_next   = mag_reg;
        dvd_next   = dvd_reg;
        avg_next   = avg_reg;
        mul_a      = MUL_A_W'(az_reg);
        mul_b      = az_reg;
        sub_a      = {rem_reg[SUB_W-3:0], acc_reg[SUMSQ_W-1 -: 2]};
        sub_b      = {1'b0, root_reg, 2'b01};
        status     = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (ctrl.start) begin
                    ax_next    = axis_abs(axes.x);
                    ay_next    = axis_abs(axes.y);
                    az_next    = axis_abs(axes.z);
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                // Square one axis per cycle, accumulate the previous product
                case (cnt_reg[1:0])
                    2'd0:    begin mul_a = MUL_A_W'(ax_reg); mul_b = ax_reg; end
                    2'd1:    begin mul_a = MUL_A_W'(ay_reg); mul_b = ay_reg; end
                    default: begin mul_a = MUL_A_W'(az_reg); mul_b = az_reg; end
                endcase
                prod_next = product;
                if (cnt_reg != '0) begin
                    acc_next = acc_reg + prod_reg[SUMSQ_W-1:0];
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == SQUARE_LAST) begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    root_next  = '0;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                // One result bit per cycle, two radicand bits consumed
                rem_next  = ge ? diff[SUB_W-1:0] : sub_a;
                root_next = {root_reg[ROOT_W-2:0], ge};
                acc_next  = {acc_reg[SUMSQ_W-3:0], 2'b00};
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == ROOT_LAST) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                mul_a      = MUL_A_W'(root_reg);
                mul_b      = lsb_scale;
                prod_next  = product;
                state_next = ST_CLAMP;
            end
            ST_CLAMP: begin
                mag_next   = (scaled > PROD_W'(MAG_MAX)) ? MAG_MAX : scaled[UG_W-1:0];
                state_next = ST_WEIGHT;
            end
            ST_WEIGHT: begin
                mul_a      = avg_reg;
                mul_b      = MUL_B_W'(filter_weight);
                prod_next  = product;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                // Quotient fits UG_W bits, so the top bits start as remainder
                rem_next   = SUB_W'(dvd_sum[DVD_W-1:UG_W]);
                dvd_next   = dvd_sum[UG_W-1:0];
                cnt_next   = '0;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                sub_a    = {{(SUB_W-DIVISOR_W-1){1'b0}}, rem_reg[DIVISOR_W-1:0],
                            dvd_reg[UG_W-1]};
                sub_b    = SUB_W'(divisor);
                rem_next = ge ? diff[SUB_W-1:0] : sub_a;
                dvd_next = {dvd_reg[UG_W-2:0], ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == DIV_LAST) begin
                    avg_next   = {dvd_reg[UG_W-2:0], ge};
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                status.done = 1'b1;
                if (ctrl.out_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        status.busy = (state_reg != ST_IDLE);
    end

    assign result.magnitude_ug = mag_reg;
    assign result.smoothed_ug  = avg_reg;

endmodule

[hw/rtl/accel_magnitude_smoother.sv]
// ----------------------------------------------------------------------------
// accel_magnitude_smoother
// Vector magnitude of accelerometer frames with an exponential moving average.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): one raw FIFO byte per transaction in s_tdata,
//   order x lo, x hi, y lo, y hi, z lo, z hi. s_tlast marks the final byte of
//   a burst; a frame left incomplete by it is dropped without a result.
//   Output stream (m_axis): one transaction per complete frame carrying the
//   scaled magnitude and the updated running average, both in micro-g.
//   Config (APB): lsb_scale at 0x0 (Q format, SCALE_FRAC_BITS fraction bits),
//   filter_weight at 0x4. Write only while the block is idle.
// Timing:
//   The first five bytes of a frame are taken one per cycle while s_tready
//   is high. The sixth byte starts the iterative unit: squaring of the
//   three axes, 16 root iterations, scale, clamp, weighting and sum, and 25
//   divide iterations; the result then goes to the output register that
//   drives m_tvalid. The root and divide loops on the shared subtractor take
//   most of the frame time. s_tready is low while the unit works.
// Reset:
//   aresetn clears the byte position, loads the running average with 0.9 g
//   and the registers with their defaults, and empties the output register.
// Stall:
//   A result waits in the output register while m_tready is low; the next
//   frame may be collected meanwhile, but its computation holds at the end
//   until the output register is free.
// ----------------------------------------------------------------------------
module accel_magnitude_smoother #(
    parameter int unsigned SCALE_FRAC_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Byte stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] fifo_byte
    input  logic        s_tlast,    // last_byte
    // Result stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata     // [24:0] magnitude_ug, [49:25] smoothed_ug
);
    import ams_pkg::*;

    logic [SCALE_W-1:0]  lsb_scale_reg;
    logic [WEIGHT_W-1:0] filter_weight_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [7:0]          frame_reg [FRAME_HELD];
    logic                m_valid_reg;
    ams_result_t         out_reg;

    ams_ctrl_t           ctrl;
    ams_status_t         status;
    ams_axes_t           axes;
    ams_result_t         result;
    logic                s_accept;
    logic                frame_end;
    logic                cfg_write;
    logic                out_free;
    logic                out_load;

    // APB: pready is tied high, every access completes in its access cycle
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lsb_scale_reg     <= LSB_SCALE_RESET;
            filter_weight_reg <= WEIGHT_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_LSB_SCALE:     lsb_scale_reg     <= pwdata[SCALE_W-1:0];
                REG_FILTER_WEIGHT: filter_weight_reg <= pwdata[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_LSB_SCALE:     prdata = 32'(lsb_scale_reg);
            REG_FILTER_WEIGHT: prdata = 32'(filter_weight_reg);
            default:           prdata = '0;
        endcase
    end

    // Frame assembly: hold the first five bytes, the sixth starts the unit
    assign s_tready  = ~status.busy;
    assign s_accept  = s_tvalid & s_tready;
    assign frame_end = (pos_reg == FINAL_POS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (s_accept) begin
            if (frame_end || s_tlast) begin
                pos_reg <= '0;     // drop a partial frame at burst end
            end else begin
                pos_reg <= pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && (pos_reg <= LAST_HELD_POS)) begin
            frame_reg[pos_reg] <= s_tdata;
        end
    end

    assign axes.x = {frame_reg[1], frame_reg[0]};
    assign axes.y = {frame_reg[3], frame_reg[2]};
    assign axes.z = {s_tdata, frame_reg[4]};

    assign ctrl.start     = s_accept & frame_end;
    assign ctrl.out_ready = out_free;

    ams_core #(
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (ctrl),
        .axes          (axes),
        .lsb_scale     (lsb_scale_reg),
        .filter_weight (filter_weight_reg),
        .status        (status),
        .result        (result)
    );

    // Output register: take a finished result when empty or being drained
    assign out_free = ~m_valid_reg | m_tready;
    assign out_load = status.done & out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, out_reg.smoothed_ug, out_reg.magnitude_ug};

endmodule
